/* rtl/core/csvft_pkg.sv */
// Shared codes and character constants for the CSV field tokenizer.
`default_nettype none

package csvft_pkg;

    localparam int KIND_W = 3;
    localparam int ERR_W  = 3;
    localparam int DATA_W = 7;
    localparam int IDX_W  = 8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EOD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NON_ASCII = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EOF_QUOTE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CR_NO_LF  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_STRAY     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_LENGTH    = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd6;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

endpackage

`default_nettype wire

/* rtl/core/csv_field_tokenizer.sv */
// CSV field tokenizer: byte-per-word parser with record length checking.
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_ready, in_byte, end_of_input          | in
//  out     | out_valid, out_ready, kind, data_byte, field_index,|
//          | error_code                                         | out
//
// One word per cycle when in_ready is high: the parser state and the result
// register both update at the accepting edge, so the result appears in the next
// cycle. Words that give no result (opening quote, CR, quote inside quotes) just
// advance the state. in_ready is low only while a result waits and out_ready is
// low. Reset clears the state to the start of a record, no width known.
`default_nettype none

module csv_field_tokenizer #(
    parameter int MAX_FIELDS = 255
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    output logic [6:0]      data_byte,
    output logic [7:0]      field_index,
    output logic [2:0]      error_code
);

    import csvft_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);
    localparam logic [CNT_W:0] MAX_EXT = (CNT_W + 1)'(MAX_FIELDS);

    typedef enum logic [2:0] {
        PH_REC_START,
        PH_FIELD_START,
        PH_UNQUOTED,
        PH_QUOTED,
        PH_QUOTE_SEEN,
        PH_CR,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DATA,
        ACT_FIELD,
        ACT_RECORD,
        ACT_EOD,
        ACT_FAIL,
        ACT_REPEAT
    } act_t;

    phase_t                 phase_reg, phase_next, phase_step;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       expected_reg, expected_next;
    logic                   known_reg, known_next;
    logic [ERR_W-1:0]       err_reg, err_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic [ERR_W-1:0]       code_reg, code_next;

    act_t                   act;
    logic [ERR_W-1:0]       fail_code;
    logic                   accept;
    logic                   emit;
    logic [CNT_W:0]         count_inc;
    logic [CNT_W+IDX_W-1:0] count_wide;
    logic                   too_many;
    logic                   len_bad;
    logic                   is_comma, is_lf, is_cr, is_quote, is_sep;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign count_inc  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign count_wide = {{IDX_W{1'b0}}, count_reg};
    assign too_many   = count_inc >= MAX_EXT;
    assign len_bad    = known_reg && (count_inc != {1'b0, expected_reg});

    assign is_comma = in_byte == CH_COMMA;
    assign is_lf    = in_byte == CH_LF;
    assign is_cr    = in_byte == CH_CR;
    assign is_quote = in_byte == CH_QUOTE;
    assign is_sep   = is_comma || is_lf || is_cr;

    // Decide what the word does, before field and record checks.
    always_comb
    begin
        act        = ACT_NONE;
        fail_code  = ERR_NONE;
        phase_step = phase_reg;
        if (phase_reg == PH_ERROR) begin
            act = ACT_REPEAT;
        end else if (phase_reg == PH_DONE) begin
            act = ACT_NONE;
        end else if (end_of_input) begin
            case (phase_reg)
                PH_REC_START:
                begin
                    act        = ACT_EOD;
                    phase_step = PH_DONE;
                end
                PH_QUOTED:
                begin
                    act       = ACT_FAIL;
                    fail_code = ERR_EOF_QUOTE;
                end
                PH_CR:
                begin
                    act       = ACT_FAIL;
                    fail_code = ERR_CR_NO_LF;
                end
                default:
                begin
                    act = ACT_RECORD;
                end
            endcase
        end else if (in_byte[7]) begin
            act       = ACT_FAIL;
            fail_code = ERR_NON_ASCII;
        end else begin
            case (phase_reg)
                PH_REC_START, PH_FIELD_START, PH_UNQUOTED:
                begin
                    if (is_quote && phase_reg != PH_UNQUOTED) begin
                        phase_step = PH_QUOTED;
                    end else if (is_comma) begin
                        act = ACT_FIELD;
                    end else if (is_lf) begin
                        act = ACT_RECORD;
                    end else if (is_cr) begin
                        phase_step = PH_CR;
                    end else begin
                        act        = ACT_DATA;
                        phase_step = PH_UNQUOTED;
                    end
                end
                PH_QUOTED:
                begin
                    if (is_quote) begin
                        phase_step = PH_QUOTE_SEEN;
                    end else begin
                        act = ACT_DATA;
                    end
                end
                PH_QUOTE_SEEN:
                begin
                    if (is_quote) begin
                        act        = ACT_DATA;
                        phase_step = PH_QUOTED;
                    end else if (is_comma) begin
                        act = ACT_FIELD;
                    end else if (is_lf) begin
                        act = ACT_RECORD;
                    end else if (is_cr) begin
                        phase_step = PH_CR;
                    end else begin
                        act       = ACT_FAIL;
                        fail_code = ERR_STRAY;
                    end
                end
                PH_CR:
                begin
                    if (is_lf) begin
                        act = ACT_RECORD;
                    end else begin
                        act       = ACT_FAIL;
                        fail_code = ERR_CR_NO_LF;
                    end
                end
                default:
                begin
                    act = ACT_NONE;
                end
            endcase
        end
        if (!is_sep && act == ACT_NONE && phase_step == PH_CR) begin
            phase_step = phase_reg;
        end
    end

    // Resolve field and record ends, build the result.
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        known_next    = known_reg;
        err_next      = err_reg;
        emit          = 1'b1;
        kind_next     = KIND_DATA;
        data_next     = '0;
        index_next    = count_wide[IDX_W-1:0];
        code_next     = ERR_NONE;
        case (act)
            ACT_NONE:
            begin
                emit       = 1'b0;
                phase_next = phase_step;
            end
            ACT_DATA:
            begin
                data_next  = in_byte[DATA_W-1:0];
                phase_next = phase_step;
            end
            ACT_FIELD:
            begin
                if (too_many) begin
                    kind_next  = KIND_ERR;
                    code_next  = ERR_TOO_MANY;
                    err_next   = ERR_TOO_MANY;
                    phase_next = PH_ERROR;
                end else begin
                    kind_next  = KIND_FEND;
                    count_next = count_inc[CNT_W-1:0];
                    phase_next = PH_FIELD_START;
                end
            end
            ACT_RECORD:
            begin
                if (len_bad) begin
                    kind_next  = KIND_ERR;
                    code_next  = ERR_LENGTH;
                    err_next   = ERR_LENGTH;
                    phase_next = PH_ERROR;
                end else begin
                    kind_next  = KIND_REND;
                    count_next = '0;
                    phase_next = PH_REC_START;
                    if (!known_reg) begin
                        expected_next = count_inc[CNT_W-1:0];
                        known_next    = 1'b1;
                    end
                end
            end
            ACT_EOD:
            begin
                kind_next  = KIND_EOD;
                index_next = '0;
                phase_next = phase_step;
            end
            ACT_FAIL:
            begin
                kind_next  = KIND_ERR;
                code_next  = fail_code;
                err_next   = fail_code;
                phase_next = PH_ERROR;
            end
            ACT_REPEAT:
            begin
                kind_next = KIND_ERR;
                code_next = err_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Drop the held result once taken, load a new one on accept.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_REC_START;
            count_reg     <= '0;
            expected_reg  <= '0;
            known_reg     <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                expected_reg <= expected_next;
                known_reg    <= known_next;
                err_reg      <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            index_reg <= index_next;
            code_reg  <= code_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign field_index = index_reg;
    assign error_code  = code_reg;

endmodule

`default_nettype wire
